// File: design/mrng_pkg.sv
// shared types and constants for the minimal standard generator with entropy mixing
`timescale 1ns / 1ps
`default_nettype none

package mrng_pkg;

    // request command codes, code 3 is unused and ignored
    typedef enum logic [1:0] {
        CMD_NEXT   = 2'd0,
        CMD_RESEED = 2'd1,
        CMD_MIX    = 2'd2
    } cmd_t;

    // lehmer recurrence constants
    localparam logic [15:0] LEHMER_MUL = 16'd48271;
    localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;

    // mixing hash constants
    localparam logic [31:0] MIX_MUL = 32'd1103515245;
    localparam logic [31:0] MIX_ADD = 32'd12345;
    localparam logic [14:0] MIX_MOD = 15'h7FFF;

    // generator state as moved between the top level and the mixer
    typedef struct packed {
        logic [14:0] mix;
        logic [31:0] main;
    } state_t;

endpackage : mrng_pkg

`default_nettype wire

// File: design/mrng_req_if.sv
// request channel interface: command, seed and entropy word
`timescale 1ns / 1ps
`default_nettype none

interface mrng_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [31:0]        seed;
    logic signed [31:0] entropy_word;

    modport source (output valid, output cmd, output seed, output entropy_word, input ready);
    modport sink   (input valid, input cmd, input seed, input entropy_word, output ready);
endinterface : mrng_req_if

`default_nettype wire

// File: design/mrng_rsp_if.sv
// response channel interface: one random value per next command
`timescale 1ns / 1ps
`default_nettype none

interface mrng_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface : mrng_rsp_if

`default_nettype wire

// File: design/mrng_lehmer.sv
// one lehmer step: (48271 * state) mod (2^31 - 1), zero state taken as one
`timescale 1ns / 1ps
`default_nettype none

module mrng_lehmer (
    input  wire logic [31:0] state,
    output logic      [30:0] value
);
    import mrng_pkg::*;

    logic [31:0] seed_val;
    logic [47:0] prod;
    logic [31:0] fold_sum;
    logic [31:0] fold_red;

    // zero state is treated as one
    assign seed_val = (state == 32'd0) ? 32'd1 : state;

    // 16 x 32 constant multiply
    assign prod = 48'(LEHMER_MUL) * 48'(seed_val);

    // mersenne fold: 2^31 is congruent to 1, then one conditional subtract
    assign fold_sum = {1'b0, prod[30:0]} + {15'd0, prod[47:31]};
    assign fold_red = (fold_sum >= {1'b0, LEHMER_MOD}) ? (fold_sum - {1'b0, LEHMER_MOD})
                                                        : fold_sum;

    assign value = fold_red[30:0];

endmodule : mrng_lehmer

`default_nettype wire

// File: design/mrng_mix.sv
// entropy mix step: hash of mix state and word, reduced mod 32767, folded into main state
`timescale 1ns / 1ps
`default_nettype none

module mrng_mix (
    input  mrng_pkg::state_t cur,
    input  wire logic [31:0] word,
    output mrng_pkg::state_t nxt
);
    import mrng_pkg::*;

    logic [31:0] hash_in;
    logic [31:0] hash_mul;
    logic [31:0] hash_out;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] fold_red;
    logic [14:0] mix_new;

    // linear congruential hash, all mod 2^32
    assign hash_in  = {17'd0, cur.mix} + word;
    assign hash_mul = 32'(hash_in * MIX_MUL);
    assign hash_out = hash_mul + MIX_ADD;

    // mod 2^15 - 1: add 15-bit digits, fold once more, one conditional subtract
    assign fold1 = {2'd0, hash_out[14:0]} + {2'd0, hash_out[29:15]}
                 + {15'd0, hash_out[31:30]};
    assign fold2 = {1'b0, fold1[14:0]} + {14'd0, fold1[16:15]};
    assign fold_red = (fold2 >= {1'b0, MIX_MOD}) ? (fold2 - {1'b0, MIX_MOD}) : fold2;
    assign mix_new  = fold_red[14:0];

    // mix and main state update
    assign nxt.mix  = mix_new;
    assign nxt.main = (cur.main << 5) ^ {14'd0, mix_new, 3'd0} ^ word;

endmodule : mrng_mix

`default_nettype wire

// File: design/minstd_rng_with_entropy_mix_unit.sv
// top level of the minimal standard generator with reseed and entropy mixing
//
//   channel  dir  handshake      payload
//   req      in   valid / ready  cmd[1:0], seed[31:0], entropy_word[31:0] signed
//   rsp      out  valid / ready  random_value[30:0], only for next requests
//
// a request is captured in the input register and executed from there, and a next
// request's value is then written into the result register
// throughput is one request per clock while no next request waits on the response side;
// the state update (constant multiply and modulo fold) is combinational into the state registers
// reset leaves main state 1 and mix state 0, no request pending
// a next request waits in the input register while a previous result is not taken;
// reseed and mix requests never wait on the response side
`timescale 1ns / 1ps
`default_nettype none

module minstd_rng_with_entropy_mix_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mrng_req_if.sink    req,
    mrng_rsp_if.source  rsp
);
    import mrng_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    cmd_t        cmd_reg;
    logic [31:0] seed_reg;
    logic [31:0] word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [30:0] out_value_reg;
    state_t      state_reg;
    state_t      state_next;

    logic        produce;
    logic        advance;
    logic        req_fire;
    logic [30:0] lehmer_value;
    state_t      mix_result;

    // handshake control
    assign produce  = in_valid_reg && (cmd_reg == CMD_NEXT);
    assign advance  = in_valid_reg && (!produce || !out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire = req.valid && req.ready;

    // datapath units
    mrng_lehmer u_lehmer (
        .state (state_reg.main),
        .value (lehmer_value)
    );

    mrng_mix u_mix (
        .cur  (state_reg),
        .word (word_reg),
        .nxt  (mix_result)
    );

    // command execution
    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            case (cmd_reg)
                CMD_NEXT:
                begin
                    state_next.main = {1'b0, lehmer_value};
                end
                CMD_RESEED:
                begin
                    state_next.mix  = seed_reg[14:0];
                    state_next.main = (seed_reg[30:0] == 31'd0) ? 32'd1
                                                                 : {1'b0, seed_reg[30:0]};
                end
                CMD_MIX:
                begin
                    state_next = mix_result;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // valid flags
    always_comb
    begin
        if (req_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && produce)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg.mix  <= 15'd0;
            state_reg.main <= 32'd1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg  <= cmd_t'(req.cmd);
            seed_reg <= req.seed;
            word_reg <= $unsigned(req.entropy_word);
        end
        if (advance && produce)
            out_value_reg <= lehmer_value;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_value_reg;

    // a result appears only after a next request was executed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && produce))
        else $error("result raised without a next request");

    // the emitted value is the new main state, below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && produce) |=> (rsp.random_value == state_reg.main[30:0])
                                 && (state_reg.main[31] == 1'b0)
                                 && (state_reg.main[30:0] != LEHMER_MOD))
        else $error("next result does not match main state");

    // reseed never leaves a zero main state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg == CMD_RESEED)) |=> (state_reg.main != 32'd0))
        else $error("reseed left zero main state");

    // mix state stays below its modulus after a mix
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg == CMD_MIX)) |=> (state_reg.mix != MIX_MOD))
        else $error("mix state out of range");

    // state only moves when a request is executed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a request");

endmodule : minstd_rng_with_entropy_mix_unit

`default_nettype wire
